// ----- hdl/hptc_pkg.sv -----
`default_nettype none
package hptc_pkg;

	localparam int RAW_T_W   = 20;
	localparam int RAW_P_W   = 20;
	localparam int RAW_H_W   = 16;
	localparam int TEMP_W    = 18;
	localparam int FINE_W    = 24;
	localparam int PRESS_W   = 32;
	localparam int HUM_W     = 17;
	localparam int NUM_W     = 64;
	localparam int DEN_W     = 31;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 64;

	// quotient bits resolved per divider stage; must divide NUM_W
	localparam int DIV_BITS_DEF = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_TEMP     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PRESS_LO = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PRESS_HI = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_MIX      = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_HUM      = 3'd4;

	localparam logic [RAW_H_W-1:0] HUM_SKIPPED = 16'h8000;
	localparam logic signed [31:0] HUM_MAX_ACC = 32'sd419430400;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [11:0] h4;
		logic [11:0] h5;
		logic [7:0]  h6;
	} calib_t;

	// results that ride alongside the pressure division
	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic [FINE_W-1:0] fine;
		logic [HUM_W-1:0]  hum;
		logic              hum_ok;
		logic              den_zero;
		logic              q_neg;
	} side_t;

	function automatic calib_t unpack_calib(input logic [47:0] tw, input logic [63:0] plo,
			input logic [63:0] phi, input logic [47:0] mw, input logic [31:0] hw);
		calib_t c;
		c.t1 = tw[15:0];
		c.t2 = tw[31:16];
		c.t3 = tw[47:32];
		c.p1 = plo[15:0];
		c.p2 = plo[31:16];
		c.p3 = plo[47:32];
		c.p4 = plo[63:48];
		c.p5 = phi[15:0];
		c.p6 = phi[31:16];
		c.p7 = phi[47:32];
		c.p8 = phi[63:48];
		c.p9 = mw[15:0];
		c.h1 = mw[23:16];
		c.h2 = mw[39:24];
		c.h3 = mw[47:40];
		c.h4 = hw[11:0];
		c.h5 = hw[23:12];
		c.h6 = hw[31:24];
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/hptc_front.sv -----
`default_nettype none
module hptc_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  hptc_pkg::calib_t             calib,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [hptc_pkg::RAW_T_W-1:0]  raw_temp,
	input  wire [hptc_pkg::RAW_P_W-1:0]  raw_press,
	input  wire [hptc_pkg::RAW_H_W-1:0]  raw_hum,
	output logic                         out_valid,
	input  wire                          out_ready,
	output hptc_pkg::side_t              out_side,
	output logic [hptc_pkg::NUM_W-1:0]   out_num,
	output logic [hptc_pkg::DEN_W-1:0]   out_den
);

	localparam int N = 15;

	logic [N:1]   vld_s;
	logic [N+1:1] rdy;

	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;
	logic signed [15:0] h2;
	logic signed [11:0] h5;
	logic signed [7:0]  h6;

	assign t2 = $signed(calib.t2);
	assign t3 = $signed(calib.t3);
	assign p2 = $signed(calib.p2);
	assign p3 = $signed(calib.p3);
	assign p4 = $signed(calib.p4);
	assign p5 = $signed(calib.p5);
	assign p6 = $signed(calib.p6);
	assign h2 = $signed(calib.h2);
	assign h5 = $signed(calib.h5);
	assign h6 = $signed(calib.h6);

	// bubbles collapse: a stage loads when it is empty or its successor moves
	assign rdy[N+1] = out_ready;
	for (genvar k = 1; k <= N; k++) begin : g_rdy
		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1]) vld_s[1] <= in_valid;
			for (int k = 2; k <= N; k++) begin
				if (rdy[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// stage registers
	logic signed [34:0] m_at_s1;
	logic [31:0]        bb_s1;
	logic [20:0]        pnum_s1, pnum_s2, pnum_s3, pnum_s4, pnum_s5, pnum_s6, pnum_s7;
	logic [31:0]        xbase_s1, xbase_s2, xbase_s3, xbase_s4, xbase_s5;
	logic               hskip_s1, hskip_s2, hskip_s3;
	logic signed [23:0] v1t_s2;
	logic signed [36:0] m_bt_s2;
	logic signed [23:0] tf_s3;
	logic signed [24:0] pv1_s4;
	logic signed [31:0] hv_s4;
	logic signed [49:0] sq_s5;
	logic signed [40:0] pp5_s5, pp2_s5, pp5_s6, pp2_s6;
	logic signed [31:0] hm5_s5, hy6_s5, hy3_s5;
	logic signed [63:0] x6_s6, x3_s6;
	logic signed [16:0] hx_s6, hx_s7, hx_s8, hx_s9, hx_s10;
	logic signed [21:0] ha1_s6;
	logic signed [31:0] ha2_s6;
	logic signed [63:0] v2_s7, w_s7;
	logic signed [31:0] hy_s7;
	logic signed [63:0] dw_s8;
	logic [63:0]        diff_s8;
	logic signed [31:0] hy2_s8;
	logic signed [30:0] den_s9;
	logic [63:0]        num_s9;
	logic signed [31:0] hy3_s9;
	logic [63:0]        num_s [10:N];
	logic [30:0]        den_s [10:N];
	logic signed [17:0] hy4_s10;
	logic signed [31:0] hvp_s11, hvp_s12, hvp_s13, hvp_s14;
	logic signed [16:0] hxx_s12;
	logic signed [31:0] hsq_s13;
	logic signed [31:0] ht_s14;
	hptc_pkg::side_t    side_s [4:N];

	// combinational terms
	logic signed [18:0] a_t;
	logic signed [16:0] b_t;
	logic signed [33:0] bsq;
	logic signed [24:0] tf_sum;
	logic signed [27:0] t5;
	logic [31:0]        xd;
	logic [31:0]        hr;
	logic signed [31:0] hv2;
	logic [31:0]        hcl;
	logic [30:0]        den_u;
	hptc_pkg::side_t    side10_d;
	hptc_pkg::side_t    sidef_d;

	always_comb begin
		a_t    = $signed({2'b00, raw_temp[19:3]}) - $signed({2'b00, calib.t1, 1'b0});
		b_t    = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, calib.t1});
		bsq    = b_t * b_t;
		tf_sum = 25'(v1t_s2) + 25'($signed(m_bt_s2[36:14]));
		t5     = 28'($signed({tf_s3, 2'b00})) + 28'(tf_s3) + 28'sd128;
		xd     = xbase_s5 - hm5_s5;
		hr     = hy3_s9 + 32'd8192;
		den_u  = den_s9;
		hv2    = hvp_s14 - 32'($signed(ht_s14[31:4]));
		priority if (hv2 < 0)
			hcl = '0;
		else if (hv2 > hptc_pkg::HUM_MAX_ACC)
			hcl = hptc_pkg::HUM_MAX_ACC;
		else
			hcl = hv2;
		side10_d          = side_s[9];
		side10_d.den_zero = (den_s9 == '0);
		side10_d.q_neg    = num_s9[63] ^ den_s9[30];
		sidef_d           = side_s[N-1];
		sidef_d.hum       = side_s[N-1].hum_ok ? hcl[28:12] : '0;
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			m_at_s1  <= a_t * t2;
			bb_s1    <= bsq[31:0];
			pnum_s1  <= 21'd1048576 - {1'b0, raw_press};
			xbase_s1 <= {2'b00, raw_hum, 14'd0} - {calib.h4, 20'd0} + 32'd16384;
			hskip_s1 <= (raw_hum == hptc_pkg::HUM_SKIPPED);
		end
		if (rdy[2]) begin
			v1t_s2   <= $signed(m_at_s1[34:11]);
			m_bt_s2  <= $signed({1'b0, bb_s1[31:12]}) * t3;
			pnum_s2  <= pnum_s1;
			xbase_s2 <= xbase_s1;
			hskip_s2 <= hskip_s1;
		end
		if (rdy[3]) begin
			tf_s3    <= $signed(tf_sum[23:0]);
			pnum_s3  <= pnum_s2;
			xbase_s3 <= xbase_s2;
			hskip_s3 <= hskip_s2;
		end
		if (rdy[4]) begin
			side_s[4].temp     <= t5[25:8];
			side_s[4].fine     <= tf_s3;
			side_s[4].hum      <= '0;
			side_s[4].hum_ok   <= !hskip_s3;
			side_s[4].den_zero <= 1'b0;
			side_s[4].q_neg    <= 1'b0;
			pv1_s4   <= 25'(tf_s3) - 25'sd128000;
			hv_s4    <= 32'(tf_s3) - 32'sd76800;
			pnum_s4  <= pnum_s3;
			xbase_s4 <= xbase_s3;
		end
		if (rdy[5]) begin
			sq_s5    <= pv1_s4 * pv1_s4;
			pp5_s5   <= pv1_s4 * p5;
			pp2_s5   <= pv1_s4 * p2;
			hm5_s5   <= hv_s4 * 32'(h5);
			hy6_s5   <= hv_s4 * 32'(h6);
			hy3_s5   <= hv_s4 * $signed({24'd0, calib.h3});
			pnum_s5  <= pnum_s4;
			xbase_s5 <= xbase_s4;
		end
		if (rdy[6]) begin
			x6_s6   <= 64'(sq_s5) * 64'(p6);
			x3_s6   <= 64'(sq_s5) * 64'(p3);
			pp5_s6  <= pp5_s5;
			pp2_s6  <= pp2_s5;
			hx_s6   <= $signed(xd[31:15]);
			ha1_s6  <= $signed(hy6_s5[31:10]);
			ha2_s6  <= 32'($signed(hy3_s5[31:11])) + 32'sd32768;
			pnum_s6 <= pnum_s5;
		end
		if (rdy[7]) begin
			v2_s7   <= x6_s6 + 64'($signed({pp5_s6, 17'd0})) + 64'($signed({p4, 35'd0}));
			w_s7    <= 64'($signed(x3_s6[63:8])) + 64'($signed({pp2_s6, 12'd0}))
				+ 64'sh0000_8000_0000_0000;
			hy_s7   <= 32'(ha1_s6) * ha2_s6;
			hx_s7   <= hx_s6;
			pnum_s7 <= pnum_s6;
		end
		if (rdy[8]) begin
			dw_s8   <= w_s7 * $signed({48'd0, calib.p1});
			diff_s8 <= {12'd0, pnum_s7, 31'd0} - v2_s7;
			hy2_s8  <= 32'($signed(hy_s7[31:10])) + 32'sd2097152;
			hx_s8   <= hx_s7;
		end
		if (rdy[9]) begin
			den_s9 <= $signed(dw_s8[63:33]);
			num_s9 <= diff_s8 * 64'd3125;
			hy3_s9 <= hy2_s8 * 32'(h2);
			hx_s9  <= hx_s8;
		end
		if (rdy[10]) begin
			num_s[10] <= num_s9[63] ? 64'd0 - num_s9 : num_s9;
			den_s[10] <= den_u[30] ? 31'd0 - den_u : den_u;
			hy4_s10   <= $signed(hr[31:14]);
			hx_s10    <= hx_s9;
		end
		if (rdy[11]) begin
			hvp_s11 <= 32'(hx_s10) * 32'(hy4_s10);
		end
		if (rdy[12]) begin
			hxx_s12 <= $signed(hvp_s11[31:15]);
			hvp_s12 <= hvp_s11;
		end
		if (rdy[13]) begin
			hsq_s13 <= 32'(hxx_s12) * 32'(hxx_s12);
			hvp_s13 <= hvp_s12;
		end
		if (rdy[14]) begin
			ht_s14  <= 32'($signed(hsq_s13[31:7])) * $signed({24'd0, calib.h1});
			hvp_s14 <= hvp_s13;
		end
		// divider flags join at stage 10, humidity result at the last stage
		for (int k = 5; k <= N; k++) begin
			if (rdy[k]) begin
				if (k == 10)
					side_s[k] <= side10_d;
				else if (k == N)
					side_s[k] <= sidef_d;
				else
					side_s[k] <= side_s[k-1];
			end
		end
		for (int k = 11; k <= N; k++) begin
			if (rdy[k]) begin
				num_s[k] <= num_s[k-1];
				den_s[k] <= den_s[k-1];
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_s[N];
	assign out_side  = side_s[N];
	assign out_num   = num_s[N];
	assign out_den   = den_s[N];

endmodule
`default_nettype wire

// ----- hdl/hptc_div.sv -----
`default_nettype none
module hptc_div #(
	parameter int DIV_BITS = hptc_pkg::DIV_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  hptc_pkg::side_t              in_side,
	input  wire [hptc_pkg::NUM_W-1:0]    in_num,
	input  wire [hptc_pkg::DEN_W-1:0]    in_den,
	output logic                         out_valid,
	input  wire                          out_ready,
	output hptc_pkg::side_t              out_side,
	output logic [hptc_pkg::NUM_W-1:0]   out_quo
);

	localparam int NW     = hptc_pkg::NUM_W;
	localparam int DW     = hptc_pkg::DEN_W;
	localparam int STAGES = NW / DIV_BITS;

	logic [STAGES-1:0] vld_s;
	logic [STAGES:0]   rdy;

	// dividend shifts out at the top while quotient bits shift in below
	logic [DW-1:0]   rem_s  [STAGES];
	logic [NW-1:0]   quo_s  [STAGES];
	logic [DW-1:0]   den_s  [STAGES];
	hptc_pkg::side_t side_s [STAGES];

	assign rdy[STAGES] = out_ready;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [DW-1:0]   rem_in, rem_n;
		logic [NW-1:0]   quo_in, quo_n;
		logic [DW-1:0]   den_in;
		hptc_pkg::side_t side_in;
		logic            vld_in;
		logic [DW:0]     trial;

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign quo_in  = in_num;
			assign den_in  = in_den;
			assign side_in = in_side;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		always_comb begin
			rem_n = rem_in;
			quo_n = quo_in;
			trial = '0;
			for (int b = 0; b < DIV_BITS; b++) begin
				trial = {rem_n, quo_n[NW-1]};
				quo_n = {quo_n[NW-2:0], 1'b0};
				if (trial >= {1'b0, den_in}) begin
					rem_n    = DW'(trial - {1'b0, den_in});
					quo_n[0] = 1'b1;
				end else begin
					rem_n = trial[DW-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_s[k]  <= rem_n;
				quo_s[k]  <= quo_n;
				den_s[k]  <= den_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[STAGES-1];
	assign out_side  = side_s[STAGES-1];
	assign out_quo   = quo_s[STAGES-1];

endmodule
`default_nettype wire

// ----- hdl/hptc_back.sv -----
`default_nettype none
module hptc_back (
	input  wire                           clk,
	input  wire                           arst_n,
	input  hptc_pkg::calib_t              calib,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  hptc_pkg::side_t               in_side,
	input  wire [hptc_pkg::NUM_W-1:0]     in_quo,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [hptc_pkg::TEMP_W-1:0]   temp_centi_c,
	output logic [hptc_pkg::FINE_W-1:0]   fine_temp,
	output logic [hptc_pkg::PRESS_W-1:0]  press_q24_8,
	output logic                          press_ok,
	output logic [hptc_pkg::HUM_W-1:0]    hum_q22_10,
	output logic                          hum_ok
);

	localparam int N = 7;

	logic [N:1]   vld_s;
	logic [N+1:1] rdy;

	assign rdy[N+1] = out_ready;
	for (genvar k = 1; k <= N; k++) begin : g_rdy
		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1]) vld_s[1] <= in_valid;
			for (int k = 2; k <= N; k++) begin
				if (rdy[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	hptc_pkg::side_t side_s [1:N];
	logic [63:0] q_s1, q_s2, q_s3, q_s4, q_s5;
	logic [63:0] ll9_s2, ll8_s2;
	logic [31:0] hl9_s2, lh9_s2, hl8_s2, lh8_s2;
	logic [63:0] pa_s3, p8q_s3, p8q_s4, p8q_s5;
	logic [63:0] llp_s4;
	logic [31:0] hlp_s4, lhp_s4;
	logic [63:0] paa_s5;
	logic [63:0] s_s6;
	logic [31:0] press_s7;
	logic        ok_s7;

	logic [63:0] x9, x8, qa1, qa3;
	logic signed [63:0] r;

	// 64-bit products are built from 32x32 partials, low 64 bits kept
	always_comb begin
		x9  = 64'($signed(calib.p9));
		x8  = 64'($signed(calib.p8));
		qa1 = 64'($signed(q_s1[63:13]));
		qa3 = 64'($signed(q_s3[63:13]));
		r   = 64'($signed(s_s6[63:8])) + 64'($signed({calib.p7, 4'd0}));
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			q_s1 <= in_side.q_neg ? 64'd0 - in_quo : in_quo;
		end
		if (rdy[2]) begin
			ll9_s2 <= x9[31:0] * qa1[31:0];
			hl9_s2 <= x9[63:32] * qa1[31:0];
			lh9_s2 <= x9[31:0] * qa1[63:32];
			ll8_s2 <= x8[31:0] * q_s1[31:0];
			hl8_s2 <= x8[63:32] * q_s1[31:0];
			lh8_s2 <= x8[31:0] * q_s1[63:32];
			q_s2   <= q_s1;
		end
		if (rdy[3]) begin
			pa_s3  <= ll9_s2 + {hl9_s2 + lh9_s2, 32'd0};
			p8q_s3 <= ll8_s2 + {hl8_s2 + lh8_s2, 32'd0};
			q_s3   <= q_s2;
		end
		if (rdy[4]) begin
			llp_s4 <= pa_s3[31:0] * qa3[31:0];
			hlp_s4 <= pa_s3[63:32] * qa3[31:0];
			lhp_s4 <= pa_s3[31:0] * qa3[63:32];
			p8q_s4 <= p8q_s3;
			q_s4   <= q_s3;
		end
		if (rdy[5]) begin
			paa_s5 <= llp_s4 + {hlp_s4 + lhp_s4, 32'd0};
			p8q_s5 <= p8q_s4;
			q_s5   <= q_s4;
		end
		if (rdy[6]) begin
			s_s6 <= q_s5 + 64'($signed(paa_s5[63:25])) + 64'($signed(p8q_s5[63:19]));
		end
		if (rdy[7]) begin
			ok_s7 <= !side_s[6].den_zero;
			priority if (side_s[6].den_zero || r[63])
				press_s7 <= '0;
			else if (r[63:32] != '0)
				press_s7 <= '1;
			else
				press_s7 <= r[31:0];
		end
		if (rdy[1]) side_s[1] <= in_side;
		for (int k = 2; k <= N; k++) begin
			if (rdy[k]) side_s[k] <= side_s[k-1];
		end
	end

	assign in_ready     = rdy[1];
	assign out_valid    = vld_s[N];
	assign temp_centi_c = side_s[N].temp;
	assign fine_temp    = side_s[N].fine;
	assign press_q24_8  = press_s7;
	assign press_ok     = ok_s7;
	assign hum_q22_10   = side_s[N].hum;
	assign hum_ok       = side_s[N].hum_ok;

endmodule
`default_nettype wire

// ----- hdl/humidity_pressure_temp_compensation_top.sv -----
// Integer compensation of one raw temperature/pressure/humidity reading per item.
// Fully pipelined: one item per clock unless m_tready stalls the output. The pressure term
// uses a restoring divider with DIV_BITS_PER_STAGE quotient bits per stage (2 by default).
// Stalls on m_tready fill empty stages first; s_tready drops only when every stage holds
// an item. Calibration words are written through cfg_we/cfg_addr/cfg_wdata; the user must
// write them only while no item is in flight, as the block itself does not enforce it.
`default_nettype none
module humidity_pressure_temp_compensation_top #(
	parameter int DIV_BITS_PER_STAGE = hptc_pkg::DIV_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [55:0]                         s_tdata,  // raw_temp, raw_press, raw_hum
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// temp_centi_c, fine_temp, press_q24_8, hum_q22_10, zero pad
	output logic [95:0]                        m_tdata,
	output logic [1:0]                         m_tuser,  // press_ok, hum_ok
	input  wire                                cfg_we,
	input  wire [hptc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire [hptc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic [47:0] calib_temp_q;
	logic [63:0] calib_press_lo_q;
	logic [63:0] calib_press_hi_q;
	logic [47:0] calib_mix_q;
	logic [31:0] calib_hum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_temp_q     <= '0;
			calib_press_lo_q <= '0;
			calib_press_hi_q <= '0;
			calib_mix_q      <= '0;
			calib_hum_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				hptc_pkg::REG_TEMP:     calib_temp_q     <= cfg_wdata[47:0];
				hptc_pkg::REG_PRESS_LO: calib_press_lo_q <= cfg_wdata;
				hptc_pkg::REG_PRESS_HI: calib_press_hi_q <= cfg_wdata;
				hptc_pkg::REG_MIX:      calib_mix_q      <= cfg_wdata[47:0];
				hptc_pkg::REG_HUM:      calib_hum_q      <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	hptc_pkg::calib_t calib;
	assign calib = hptc_pkg::unpack_calib(calib_temp_q, calib_press_lo_q, calib_press_hi_q,
		calib_mix_q, calib_hum_q);

	logic                            f_valid, f_ready;
	hptc_pkg::side_t                 f_side;
	logic [hptc_pkg::NUM_W-1:0]      f_num;
	logic [hptc_pkg::DEN_W-1:0]      f_den;
	logic                            d_valid, d_ready;
	hptc_pkg::side_t                 d_side;
	logic [hptc_pkg::NUM_W-1:0]      d_quo;

	logic [hptc_pkg::TEMP_W-1:0]     temp_centi_c;
	logic [hptc_pkg::FINE_W-1:0]     fine_temp;
	logic [hptc_pkg::PRESS_W-1:0]    press_q24_8;
	logic                            press_ok;
	logic [hptc_pkg::HUM_W-1:0]      hum_q22_10;
	logic                            hum_ok;

	hptc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.calib     (calib),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.raw_temp  (s_tdata[19:0]),
		.raw_press (s_tdata[39:20]),
		.raw_hum   (s_tdata[55:40]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_side  (f_side),
		.out_num   (f_num),
		.out_den   (f_den)
	);

	hptc_div #(
		.DIV_BITS (DIV_BITS_PER_STAGE)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_side   (f_side),
		.in_num    (f_num),
		.in_den    (f_den),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_side  (d_side),
		.out_quo   (d_quo)
	);

	hptc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.calib        (calib),
		.in_valid     (d_valid),
		.in_ready     (d_ready),
		.in_side      (d_side),
		.in_quo       (d_quo),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.temp_centi_c (temp_centi_c),
		.fine_temp    (fine_temp),
		.press_q24_8  (press_q24_8),
		.press_ok     (press_ok),
		.hum_q22_10   (hum_q22_10),
		.hum_ok       (hum_ok)
	);

	assign m_tdata = {5'd0, hum_q22_10, press_q24_8, fine_temp, temp_centi_c};
	assign m_tuser = {hum_ok, press_ok};

	// input side only backs up when the whole pipe is full and the output is stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while pipeline has room");

	a_hum_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hum_q22_10 <= 17'd102400))
		else $error("humidity above 100 percent");

	a_hum_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !hum_ok) |-> (hum_q22_10 == '0))
		else $error("skipped humidity item carries nonzero value");

	a_press_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !press_ok) |-> (press_q24_8 == '0))
		else $error("zero-divisor pressure item carries nonzero value");

endmodule
`default_nettype wire

// ----- tb/tb_humidity_pressure_temp_compensation_top.sv -----
`default_nettype none
module tb_humidity_pressure_temp_compensation_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 80;    // pipeline depth is 54 at default divider
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic signed [hptc_pkg::TEMP_W-1:0] temp;
		logic signed [hptc_pkg::FINE_W-1:0] fine;
		logic [hptc_pkg::PRESS_W-1:0]       press;
		logic                               press_ok;
		logic [hptc_pkg::HUM_W-1:0]         hum;
		logic                               hum_ok;
	} reading_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [55:0] s_tdata;   // raw_temp, raw_press, raw_hum
	logic m_tvalid;
	logic m_tready;
	logic [95:0] m_tdata;   // temp_centi_c, fine_temp, press_q24_8, hum_q22_10, zero pad
	logic [1:0] m_tuser;    // press_ok, hum_ok
	logic cfg_we;
	logic [hptc_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [hptc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// local copy of the calibration words
	logic [47:0] cal_temp;
	logic [63:0] cal_press_lo;
	logic [63:0] cal_press_hi;
	logic [47:0] cal_mix;
	logic [31:0] cal_hum;

	reading_t expected_q[$];
	int err_count;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	humidity_pressure_temp_compensation_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint div_trunc(longint a, longint d);
		if (d == -64'sd1)
			return -a;
		return a / d;
	endfunction

	function automatic reading_t compensate(logic [19:0] raw_t, logic [19:0] raw_p,
			logic [15:0] raw_h);
		reading_t r;
		longint adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint a, b, v1, v2, tf, p;
		int adc_h, h1, h2, h3, h4, h5, h6, hv, x, y;
		adc_t = longint'(raw_t);
		adc_p = longint'(raw_p);
		adc_h = int'(raw_h);
		t1 = longint'(cal_temp[15:0]);
		t2 = longint'($signed(cal_temp[31:16]));
		t3 = longint'($signed(cal_temp[47:32]));
		p1 = longint'(cal_press_lo[15:0]);
		p2 = longint'($signed(cal_press_lo[31:16]));
		p3 = longint'($signed(cal_press_lo[47:32]));
		p4 = longint'($signed(cal_press_lo[63:48]));
		p5 = longint'($signed(cal_press_hi[15:0]));
		p6 = longint'($signed(cal_press_hi[31:16]));
		p7 = longint'($signed(cal_press_hi[47:32]));
		p8 = longint'($signed(cal_press_hi[63:48]));
		p9 = longint'($signed(cal_mix[15:0]));
		h1 = int'(cal_mix[23:16]);
		h2 = int'($signed(cal_mix[39:24]));
		h3 = int'(cal_mix[47:40]);
		h4 = int'($signed(cal_hum[11:0]));
		h5 = int'($signed(cal_hum[23:12]));
		h6 = int'($signed(cal_hum[31:24]));

		a = (adc_t >> 3) - (t1 << 1);
		v1 = (a * t2) >>> 11;
		b = (adc_t >> 4) - t1;
		v2 = (((b * b) >>> 12) * t3) >>> 14;
		tf = v1 + v2;
		r.fine = tf[hptc_pkg::FINE_W-1:0];
		p = (tf * 5 + 128) >>> 8;
		r.temp = p[hptc_pkg::TEMP_W-1:0];

		v1 = tf - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		r.press = '0;
		r.press_ok = 1'b0;
		if (v1 != 0) begin
			p = 64'sd1048576 - adc_p;
			p = div_trunc(((p << 31) - v2) * 64'sd3125, v1);
			a = p >>> 13;
			v2 = (p8 * p) >>> 19;
			v1 = (p9 * a * a) >>> 25;
			p = ((p + v1 + v2) >>> 8) + (p7 << 4);
			if (p < 0)
				r.press = '0;
			else if (p > 64'sd4294967295)
				r.press = '1;
			else
				r.press = p[31:0];
			r.press_ok = 1'b1;
		end

		r.hum = '0;
		r.hum_ok = 1'b0;
		if (raw_h != hptc_pkg::HUM_SKIPPED) begin
			hv = int'(tf[31:0]) - 76800;
			x = ((adc_h << 14) - (h4 << 20) - h5 * hv + 16384) >>> 15;
			y = ((hv * h6) >>> 10) * (((hv * h3) >>> 11) + 32768);
			y = (y >>> 10) + 2097152;
			y = (y * h2 + 8192) >>> 14;
			hv = x * y;
			x = hv >>> 15;
			hv = hv - ((((x * x) >>> 7) * h1) >>> 4);
			if (hv < 0)
				hv = 0;
			else if (hv > hptc_pkg::HUM_MAX_ACC)
				hv = hptc_pkg::HUM_MAX_ACC;
			hv = hv >> 12;
			r.hum = hv[hptc_pkg::HUM_W-1:0];
			r.hum_ok = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] exp_val);
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, exp_val, $realtime);
		err_count++;
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		reading_t e;
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected item", m_tdata[63:0], 64'd0);
			end else begin
				e = expected_q.pop_front();
				if (m_tdata[17:0] !== e.temp)
					report_mismatch("temp_centi_c", m_tdata[17:0], e.temp);
				if (m_tdata[41:18] !== e.fine)
					report_mismatch("fine_temp", m_tdata[41:18], e.fine);
				if (m_tdata[73:42] !== e.press)
					report_mismatch("press_q24_8", m_tdata[73:42], e.press);
				if (m_tdata[90:74] !== e.hum)
					report_mismatch("hum_q22_10", m_tdata[90:74], e.hum);
				if (m_tuser[0] !== e.press_ok)
					report_mismatch("press_ok", m_tuser[0], e.press_ok);
				if (m_tuser[1] !== e.hum_ok)
					report_mismatch("hum_ok", m_tuser[1], e.hum_ok);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_humidity_pressure_temp_compensation_top: done, errors");
			$finish;
		end
	end

	task automatic send_reading(logic [19:0] raw_t, logic [19:0] raw_p, logic [15:0] raw_h);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {raw_h, raw_p, raw_t};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_q.push_back(compensate(raw_t, raw_p, raw_h));
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (expected_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_calib(logic [hptc_pkg::CFG_ADDR_W-1:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			hptc_pkg::REG_TEMP:     cal_temp = val[47:0];
			hptc_pkg::REG_PRESS_LO: cal_press_lo = val;
			hptc_pkg::REG_PRESS_HI: cal_press_hi = val;
			hptc_pkg::REG_MIX:      cal_mix = val[47:0];
			hptc_pkg::REG_HUM:      cal_hum = val[31:0];
			default:      ;
		endcase
	endtask

	task automatic load_calib(logic [63:0] tw, logic [63:0] plo, logic [63:0] phi,
			logic [63:0] mw, logic [63:0] hw);
		write_calib(hptc_pkg::REG_TEMP, tw);
		write_calib(hptc_pkg::REG_PRESS_LO, plo);
		write_calib(hptc_pkg::REG_PRESS_HI, phi);
		write_calib(hptc_pkg::REG_MIX, mw);
		write_calib(hptc_pkg::REG_HUM, hw);
	endtask

	// typical part: T1..T3, P1..P9, H1..H6
	task automatic load_typical_calib;
		load_calib({16'hFC18, 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, 16'hD843, 16'd36477},
			{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
			{8'd0, 16'd362, 8'd75, 16'd6000},
			{8'd30, 12'd0, 12'd324});
	endtask

	task automatic send_extremes;
		send_reading(20'h0, 20'h0, 16'h0);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_reading(20'h0, 20'hFFFFF, hptc_pkg::HUM_SKIPPED);
		send_reading(20'hFFFFF, 20'h0, 16'h7FFF);
		send_reading(20'h80000, 20'h80000, 16'h8001);
		send_reading(20'h7E000, 20'h5A000, 16'h6800);
		send_reading(20'h84000, 20'h4F000, hptc_pkg::HUM_SKIPPED);
		send_reading(20'h55555, 20'hAAAAA, 16'h5555);
		send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
	endtask

	// all-zero calibration: pressure divisor is zero
	task automatic test_zero_calib;
		send_extremes();
		drain();
	endtask

	task automatic test_typical_calib;
		load_typical_calib();
		send_extremes();
		drain();
	endtask

	task automatic test_extreme_calib;
		load_calib('1, '1, '1, '1, '1);
		send_extremes();
		drain();
		load_calib({16'h7FFF, 16'h7FFF, 16'hFFFF}, {4{16'h8000}} | 64'hFFFF,
			{4{16'h7FFF}}, {8'hFF, 16'h7FFF, 8'hFF, 16'h8000}, {8'h7F, 12'h800, 12'h7FF});
		send_extremes();
		drain();
		load_calib({16'h8000, 16'h8000, 16'h0000}, {4{16'h7FFF}},
			{4{16'h8000}}, {8'h00, 16'h8000, 8'h00, 16'h7FFF}, {8'h80, 12'h7FF, 12'h800});
		send_extremes();
		drain();
	endtask

	// writes past the last register must leave calibration untouched
	task automatic test_unused_index;
		load_typical_calib();
		write_calib(hptc_pkg::CFG_ADDR_W'(5), '1);
		write_calib(hptc_pkg::CFG_ADDR_W'(6), 64'h1234_5678_9ABC_DEF0);
		write_calib(hptc_pkg::CFG_ADDR_W'(7), '0);
		send_extremes();
		drain();
	endtask

	function automatic logic [15:0] jitter(logic [15:0] v, int span);
		return v + 16'($urandom_range(2 * span)) - 16'(span);
	endfunction

	task automatic random_phase(int count, bit wild_calib);
		logic [15:0] h;
		if (wild_calib) begin
			load_calib({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
		end else begin
			load_calib({jitter(16'hFC18, 500), jitter(16'd26435, 2000), jitter(16'd27504, 2000)},
				{jitter(16'd2855, 500), jitter(16'd3024, 500), jitter(16'hD843, 1000),
					jitter(16'd36477, 3000)},
				{jitter(16'hC6F8, 500), jitter(16'd15500, 500), jitter(16'hFFF9, 5),
					jitter(16'd140, 50)},
				{8'($urandom), jitter(16'd362, 100), 8'($urandom), jitter(16'd6000, 500)},
				{8'($urandom_range(60)), 12'($urandom_range(100)), 12'($urandom_range(600))});
		end
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0: h = hptc_pkg::HUM_SKIPPED;
				1, 2: h = 16'($urandom);
				default: h = 16'($urandom_range(16'h8800, 16'h5000));
			endcase
			if ($urandom_range(3) == 0)
				send_reading(20'($urandom), 20'($urandom), h);
			else
				send_reading(20'($urandom_range(20'h90000, 20'h70000)),
					20'($urandom_range(20'h70000, 20'h40000)), h);
			if (n == count / 2 && !wild_calib) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				wait (expected_q.size() == 0);
			end
		end
		drain();
	endtask

	task automatic test_random;
		for (int ph = 0; ph < 7; ph++) begin
			send_idle_pct = (ph == 2) ? 0 : 18;
			recv_stall_pct = (ph == 2) ? 0 : 18;
			random_phase(100, ph % 3 == 1);
		end
		send_idle_pct = 18;
		recv_stall_pct = 18;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		cal_temp = '0;
		cal_press_lo = '0;
		cal_press_hi = '0;
		cal_mix = '0;
		cal_hum = '0;
		err_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 18;
		recv_stall_pct = 18;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_calib();
		test_typical_calib();
		test_extreme_calib();
		test_unused_index();
		test_random();

		if (err_count == 0)
			$display("tb_humidity_pressure_temp_compensation_top: done, clean");
		else
			$display("tb_humidity_pressure_temp_compensation_top: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
